/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion helper macros
// clocked property checks that compile away for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every rising edge, suspended while reset is asserted
`define ASSERT_AT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
// property checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("assertion failed");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* design/mmrf_pkg.sv */
// ----------------------------------------------------------------------------
// mmrf_pkg
// shared types, codes and helpers of the memory mapper register file
// ----------------------------------------------------------------------------
`default_nettype none

package mmrf_pkg;

	localparam int REGION_COUNT_DEFAULT = 8;
	localparam int REGION_COUNT_MAX     = 8;

	localparam int RF_DEPTH   = 32;
	localparam int RF_IDX_W   = 5;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 80;

	// opcodes
	localparam logic [2:0] OP_READ     = 3'd0;
	localparam logic [2:0] OP_WRITE    = 3'd1;
	localparam logic [2:0] OP_RETURN   = 3'd2;
	localparam logic [2:0] OP_MAILBOX  = 3'd3;
	localparam logic [2:0] OP_CONSUME  = 3'd4;

	// bus request codes
	localparam logic [1:0] BUS_NONE  = 2'd0;
	localparam logic [1:0] BUS_READ  = 2'd1;
	localparam logic [1:0] BUS_WRITE = 2'd2;

	// register indexes
	localparam logic [4:0] REG_DATA_HI  = 5'd0;
	localparam logic [4:0] REG_DATA_LO  = 5'd1;
	localparam logic [4:0] REG_STATUS   = 5'd2;
	localparam logic [4:0] REG_SOUND    = 5'd3;
	localparam logic [4:0] REG_COMMAND  = 5'd5;
	localparam int         REG_RD_ADDR  = 7;
	localparam int         REG_WR_ADDR  = 10;
	localparam int         REG_REGION   = 16;

	// command register values
	localparam logic [7:0] CMD_READ  = 8'h02;
	localparam logic [7:0] CMD_WRITE = 8'h01;

	localparam logic [7:0] IDLE_BYTE   = 8'hFF;
	localparam logic [7:0] STATUS_RUN  = 8'h0F;
	localparam logic [7:0] STATUS_HALT = 8'h00;

	typedef struct packed {
		logic [15:0] return_word;
		logic [7:0]  data;
		logic [23:0] address;
		logic [2:0]  opcode;
	} item_t;

	typedef struct packed {
		logic        hit;
		logic [2:0]  index;
		logic [20:0] offset;
	} dec_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [1:0]  bus_request;
		logic [23:0] bus_address;
		logic [15:0] bus_write_data;
		logic        sound_irq;
	} rf_res_t;

	function automatic logic [23:0] size_mask(input logic [1:0] code);
		logic [23:0] m;
		case (code)
			2'd0:    m = 24'h00FFFF;
			2'd1:    m = 24'h01FFFF;
			2'd2:    m = 24'h07FFFF;
			default: m = 24'h1FFFFF;
		endcase
		return m;
	endfunction

	// word address spread over three registers, bits 23:17, 16:9 and 8:1
	function automatic logic [23:0] ind_addr(input logic [7:0] hi, input logic [7:0] mid,
			input logic [7:0] lo);
		return {hi[6:0], 17'd0} | {7'd0, mid, 9'd0} | {15'd0, lo, 1'b0};
	endfunction

endpackage

`default_nettype wire

/* design/mmrf_decode.sv */
// ----------------------------------------------------------------------------
// mmrf_decode
// parallel region compare with lowest-region priority
// ----------------------------------------------------------------------------
`default_nettype none

module mmrf_decode #(
	parameter int REGION_COUNT = mmrf_pkg::REGION_COUNT_DEFAULT
) (
	input  wire logic                          access,
	input  wire logic [23:0]                   address,
	input  wire logic [REGION_COUNT-1:0][1:0]  region_size,
	input  wire logic [REGION_COUNT-1:0][7:0]  region_base,
	output mmrf_pkg::dec_t                     dec
);
	import mmrf_pkg::*;

	always_comb begin
		logic [23:0] mask;
		dec = '0;
		// descend so the lowest matching region is assigned last
		for (int r = REGION_COUNT - 1; r >= 0; r--) begin
			mask = size_mask(region_size[r]);
			if (access && ((address & ~mask) == ({region_base[r], 16'd0} & ~mask))) begin
				dec.hit    = 1'b1;
				dec.index  = 3'(r);
				dec.offset = address[20:0] & mask[20:0];
			end
		end
	end

endmodule

`default_nettype wire

/* design/mmrf_regfile.sv */
// ----------------------------------------------------------------------------
// mmrf_regfile
// register bank, sound mailbox and latch, indirect bus command
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mmrf_regfile #(
	parameter int REGION_COUNT = mmrf_pkg::REGION_COUNT_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire mmrf_pkg::item_t               item,
	input  wire logic                          hit,
	output logic [REGION_COUNT-1:0][1:0]       region_size,
	output logic [REGION_COUNT-1:0][7:0]       region_base,
	output mmrf_pkg::rf_res_t                  res
);
	import mmrf_pkg::*;

	logic [7:0] rf_q [RF_DEPTH];
	logic [7:0] latch_q;
	logic [7:0] mailbox_q;
	logic       irq_q;

	logic [RF_IDX_W-1:0] idx;
	logic                odd;
	logic                file_rd;
	logic                file_wr;

	assign idx     = item.address[RF_IDX_W:1];
	assign odd     = item.address[0];
	assign file_rd = (item.opcode == OP_READ) && !hit && odd;
	assign file_wr = (item.opcode == OP_WRITE) && !hit && odd;

	for (genvar r = 0; r < REGION_COUNT; r++) begin : g_region
		assign region_size[r] = rf_q[REG_REGION + 2 * r][1:0];
		assign region_base[r] = rf_q[REG_REGION + 2 * r + 1];
	end

	always_comb begin
		res = '0;
		res.read_data = IDLE_BYTE;
		if (file_rd) begin
			case (idx)
				REG_DATA_HI: res.read_data = rf_q[REG_DATA_HI];
				REG_DATA_LO: res.read_data = rf_q[REG_DATA_LO];
				REG_STATUS:  res.read_data = (rf_q[REG_STATUS][1:0] == 2'b11) ?
					STATUS_HALT : STATUS_RUN;
				REG_SOUND:   res.read_data = mailbox_q;
				default:     res.read_data = IDLE_BYTE;
			endcase
		end else if (item.opcode == OP_CONSUME) begin
			res.read_data = latch_q;
		end
		if (file_wr && idx == REG_COMMAND) begin
			if (item.data == CMD_READ) begin
				res.bus_request = BUS_READ;
				res.bus_address = ind_addr(rf_q[REG_RD_ADDR], rf_q[REG_RD_ADDR + 1],
					rf_q[REG_RD_ADDR + 2]);
			end else if (item.data == CMD_WRITE) begin
				res.bus_request    = BUS_WRITE;
				res.bus_address    = ind_addr(rf_q[REG_WR_ADDR], rf_q[REG_WR_ADDR + 1],
					rf_q[REG_WR_ADDR + 2]);
				res.bus_write_data = {rf_q[REG_DATA_HI], rf_q[REG_DATA_LO]};
			end
		end
		// interrupt state as it stands after this beat
		if (file_wr && idx == REG_SOUND) begin
			res.sound_irq = 1'b1;
		end else if (item.opcode == OP_CONSUME) begin
			res.sound_irq = 1'b0;
		end else begin
			res.sound_irq = irq_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RF_DEPTH; i++) begin
				rf_q[i] <= '0;
			end
			latch_q   <= '0;
			mailbox_q <= '0;
			irq_q     <= 1'b0;
		end else if (en) begin
			irq_q <= res.sound_irq;
			if (file_wr) begin
				rf_q[idx] <= item.data;
				if (idx == REG_SOUND) begin
					latch_q <= item.data;
				end
			end
			if (item.opcode == OP_RETURN) begin
				rf_q[REG_DATA_HI] <= item.return_word[15:8];
				rf_q[REG_DATA_LO] <= item.return_word[7:0];
			end
			if (item.opcode == OP_MAILBOX) begin
				mailbox_q <= item.data;
			end
		end
	end

	`ASSERT_AT(a_consume_clears_irq, clk, arst_n, (en && item.opcode == OP_CONSUME) |=> !irq_q)
	`ASSERT_AT(a_hit_is_quiet, clk, arst_n, hit |-> (res.bus_request == BUS_NONE && res.read_data == IDLE_BYTE))
	`ASSERT_AT(a_irq_tracks, clk, arst_n, en |=> (irq_q == $past(res.sound_irq)))

endmodule

`default_nettype wire

/* design/memory_mapper_register_file_core.sv */
// ----------------------------------------------------------------------------
// memory_mapper_register_file_core
// region decoder and register file behind a stream interface
// ----------------------------------------------------------------------------
// usage:
//   one bus access per beat on the s_axis side; one result beat per access
//   on the m_axis side, in order
//   the beat lands in an input register, region decode and register file
//   access run combinationally on it and the result is written into the
//   output register when the beat advances
//   throughput is one beat per cycle when not stalled: the input register
//   is refilled in the same cycle it hands its beat to the output register
//   register file side effects (stores, sound latch, interrupt) take place
//   when the beat moves into the output register
//   reset clears the register file, sound latch, mailbox and interrupt and
//   empties both pipeline registers
//   when m_axis_tready is low the output register holds, one more beat may
//   wait in the input register, and then s_axis_tready drops
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module memory_mapper_register_file_core #(
	parameter int REGION_COUNT = mmrf_pkg::REGION_COUNT_DEFAULT
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// opcode, address, data, return_word, zero pad
	input  wire logic [mmrf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// read_data, region_hit, region_index, region_offset, bus_request,
	// bus_address, bus_write_data, sound_irq, zero pad
	output logic [mmrf_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);
	import mmrf_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	logic    valid_s2;
	logic    advance;
	logic    access;
	dec_t    dec;
	rf_res_t rf_res;
	dec_t    dec_s2;
	rf_res_t rf_s2;

	logic [REGION_COUNT-1:0][1:0] region_size;
	logic [REGION_COUNT-1:0][7:0] region_base;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign access        = (item_s1.opcode == OP_READ) || (item_s1.opcode == OP_WRITE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= item_t'(s_axis_tdata[$bits(item_t)-1:0]);
		end
	end

	mmrf_decode #(.REGION_COUNT(REGION_COUNT)) u_decode (
		.access      (access),
		.address     (item_s1.address),
		.region_size (region_size),
		.region_base (region_base),
		.dec         (dec)
	);

	mmrf_regfile #(.REGION_COUNT(REGION_COUNT)) u_regfile (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.item        (item_s1),
		.hit         (dec.hit),
		.region_size (region_size),
		.region_base (region_base),
		.res         (rf_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dec_s2 <= dec;
			rf_s2  <= rf_res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'd0, rf_s2.sound_irq, rf_s2.bus_write_data, rf_s2.bus_address,
		rf_s2.bus_request, dec_s2.offset, dec_s2.index, dec_s2.hit, rf_s2.read_data};

	`ASSERT_AT(a_full_stall_blocks, clk, arst_n, (valid_s1 && valid_s2 && !m_axis_tready) |-> !s_axis_tready)
	`ASSERT_AT(a_result_drops_taken, clk, arst_n, $fell(valid_s2) |-> $past(m_axis_tready))
	`ASSERT_AT(a_advance_fills, clk, arst_n, advance |=> valid_s2)
	`ASSERT_AT(a_hit_only_access, clk, arst_n, dec.hit |-> access)

endmodule

`default_nettype wire
